// ===== design/dual_stepper_turn_sequencer_assert.svh =====
// assertion macros for the turn sequencer checker
// clk and rst_n are taken from the scope where a macro is used
`ifndef DUAL_STEPPER_TURN_SEQUENCER_ASSERT_SVH
`define DUAL_STEPPER_TURN_SEQUENCER_ASSERT_SVH

// condition holds in the same cycle
`define DSTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define DSTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dsts_pkg.sv =====
`timescale 1ns / 1ps

package dsts_pkg;

    localparam int PERIOD_W = 8;
    localparam int TARGET_W = 10;
    localparam int DIR_W    = 2;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    typedef enum logic [2:0] {
        REG_LEFT_PERIOD,
        REG_LEFT_TARGET,
        REG_LEFT_DIR,
        REG_RIGHT_PERIOD,
        REG_RIGHT_TARGET,
        REG_RIGHT_DIR
    } reg_idx_t;

    localparam logic [PERIOD_W-1:0] RST_PERIOD    = 8'd30;
    localparam logic [TARGET_W-1:0] RST_TARGET    = 10'd180;
    localparam logic [DIR_W-1:0]    RST_LEFT_DIR  = DIR_FWD;
    localparam logic [DIR_W-1:0]    RST_RIGHT_DIR = DIR_REV;
    localparam logic [IDX_W-1:0]    RST_PHASE_IDX = 3'd7;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TARGET_W-1:0] target;
        logic [DIR_W-1:0]    dir;
    } wheel_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             met;
    } wheel_stat_t;

    function automatic logic dir_active(input logic [DIR_W-1:0] dir);
        return (dir == DIR_FWD) || (dir == DIR_REV);
    endfunction

    // half-step coil sequence, left wheel
    function automatic logic [3:0] left_coil(input logic [IDX_W-1:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0:    v = 4'hC;
            3'd1:    v = 4'h4;
            3'd2:    v = 4'h6;
            3'd3:    v = 4'h2;
            3'd4:    v = 4'h3;
            3'd5:    v = 4'h1;
            3'd6:    v = 4'h9;
            3'd7:    v = 4'h8;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

    // right wheel runs its own coil order
    function automatic logic [3:0] right_coil(input logic [IDX_W-1:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0:    v = 4'hC;
            3'd1:    v = 4'h8;
            3'd2:    v = 4'h9;
            3'd3:    v = 4'h1;
            3'd4:    v = 4'h3;
            3'd5:    v = 4'h2;
            3'd6:    v = 4'h6;
            3'd7:    v = 4'h4;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/dsts_regs.sv =====
`timescale 1ns / 1ps

module dsts_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsts_pkg::ADDR_W-1:0]   paddr,
    input  logic [dsts_pkg::DATA_W-1:0]   pwdata,
    output logic [dsts_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output dsts_pkg::wheel_cfg_t          left_cfg,
    output dsts_pkg::wheel_cfg_t          right_cfg
);
    import dsts_pkg::*;

    wheel_cfg_t left_reg;
    wheel_cfg_t right_reg;
    logic [2:0] reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg.period  <= RST_PERIOD;
            left_reg.target  <= RST_TARGET;
            left_reg.dir     <= RST_LEFT_DIR;
            right_reg.period <= RST_PERIOD;
            right_reg.target <= RST_TARGET;
            right_reg.dir    <= RST_RIGHT_DIR;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_LEFT_PERIOD:  left_reg.period  <= pwdata[PERIOD_W-1:0];
                REG_LEFT_TARGET:  left_reg.target  <= pwdata[TARGET_W-1:0];
                REG_LEFT_DIR:     left_reg.dir     <= pwdata[DIR_W-1:0];
                REG_RIGHT_PERIOD: right_reg.period <= pwdata[PERIOD_W-1:0];
                REG_RIGHT_TARGET: right_reg.target <= pwdata[TARGET_W-1:0];
                REG_RIGHT_DIR:    right_reg.dir    <= pwdata[DIR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LEFT_PERIOD:  prdata = {{(DATA_W-PERIOD_W){1'b0}}, left_reg.period};
            REG_LEFT_TARGET:  prdata = {{(DATA_W-TARGET_W){1'b0}}, left_reg.target};
            REG_LEFT_DIR:     prdata = {{(DATA_W-DIR_W){1'b0}}, left_reg.dir};
            REG_RIGHT_PERIOD: prdata = {{(DATA_W-PERIOD_W){1'b0}}, right_reg.period};
            REG_RIGHT_TARGET: prdata = {{(DATA_W-TARGET_W){1'b0}}, right_reg.target};
            REG_RIGHT_DIR:    prdata = {{(DATA_W-DIR_W){1'b0}}, right_reg.dir};
            default:          prdata = '0;
        endcase
    end

    assign left_cfg  = left_reg;
    assign right_cfg = right_reg;

endmodule

// ===== design/dsts_wheel.sv =====
`timescale 1ns / 1ps

module dsts_wheel (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsts_pkg::wheel_cfg_t cfg,
    input  logic                 step_en,
    input  logic                 clear,
    input  logic [2:0]           idx_init,
    output dsts_pkg::wheel_stat_t stat
);
    import dsts_pkg::*;

    logic [PERIOD_W-1:0] phase_reg;
    logic [PERIOD_W-1:0] phase_next;
    logic [TARGET_W-1:0] steps_reg;
    logic [TARGET_W-1:0] steps_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;

    logic [PERIOD_W:0]   limit;
    logic [PERIOD_W:0]   phase_inc;
    logic                elapsed;
    logic [PERIOD_W-1:0] phase_new;
    logic [TARGET_W-1:0] steps_new;

    always_comb
    begin
        // a zero period counts as the full 256 ticks
        limit     = (cfg.period == '0) ? {1'b1, {PERIOD_W{1'b0}}} : {1'b0, cfg.period};
        phase_inc = {1'b0, phase_reg} + {{PERIOD_W{1'b0}}, 1'b1};
        elapsed   = (phase_inc >= limit);
        phase_new = phase_reg;
        steps_new = steps_reg;
        idx_next  = idx_reg;
        if (step_en)
        begin
            phase_new = elapsed ? '0 : phase_inc[PERIOD_W-1:0];
            if (elapsed && (steps_reg < cfg.target))
            begin
                steps_new = steps_reg + {{(TARGET_W-1){1'b0}}, 1'b1};
                case (cfg.dir)
                    DIR_FWD: idx_next = idx_reg + {{(IDX_W-1){1'b0}}, 1'b1};
                    DIR_REV: idx_next = idx_reg - {{(IDX_W-1){1'b0}}, 1'b1};
                    default: idx_next = idx_reg;
                endcase
            end
        end
        // met is judged before the end-of-turn clear
        stat.idx = idx_next;
        stat.met = (steps_new >= cfg.target);
        phase_next = clear ? '0 : phase_new;
        steps_next = clear ? '0 : steps_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            steps_reg <= '0;
            idx_reg   <= idx_init;
        end
        else
        begin
            phase_reg <= phase_next;
            steps_reg <= steps_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== design/dual_stepper_turn_sequencer.sv =====
`timescale 1ns / 1ps
// a tick request passes the input register, then the result register
// throughput: one tick request per cycle while out_stall is low; the input and
// result registers hold one request each, so one enters while a result waits
// reset: tick and step counters clear, phase indices go to 7, registers
// take their defaults (period 30, target 180, left forward, right reverse)

module dual_stepper_turn_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsts_pkg::ADDR_W-1:0] paddr,
    input  logic [dsts_pkg::DATA_W-1:0] pwdata,
    output logic [dsts_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        tick_valid,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  coil_pattern,
    output logic                        turn_done
);
    import dsts_pkg::*;

    wheel_cfg_t  left_cfg;
    wheel_cfg_t  right_cfg;
    wheel_stat_t left_stat;
    wheel_stat_t right_stat;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_tick_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] coil_reg;
    logic       done_reg;

    logic       advance;
    logic       in_accept;
    logic       step_en;
    logic       done;
    logic [7:0] coil;

    dsts_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .left_cfg  (left_cfg),
        .right_cfg (right_cfg)
    );

    dsts_wheel u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (left_cfg),
        .step_en  (step_en),
        .clear    (done),
        .idx_init (RST_PHASE_IDX),
        .stat     (left_stat)
    );

    dsts_wheel u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (right_cfg),
        .step_en  (step_en),
        .clear    (done),
        .idx_init (RST_PHASE_IDX),
        .stat     (right_stat)
    );

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign step_en   = s1_valid_reg && advance && s1_tick_reg;
    assign done      = step_en && left_stat.met && right_stat.met;

    always_comb
    begin
        coil[3:0] = dir_active(left_cfg.dir)  ? left_coil(left_stat.idx)   : 4'h0;
        coil[7:4] = dir_active(right_cfg.dir) ? right_coil(right_stat.idx) : 4'h0;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_tick_reg <= tick_valid;
        if (advance && s1_valid_reg)
        begin
            coil_reg <= coil;
            done_reg <= done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coil_pattern = coil_reg;
    assign turn_done    = done_reg;

endmodule

// ===== design/dsts_checker.sv =====
`timescale 1ns / 1ps
`include "dual_stepper_turn_sequencer_assert.svh"

module dsts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] coil_pattern,
    input logic       turn_done
);

    // a held result keeps its payload
    `DSTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(coil_pattern) && $stable(turn_done), "stalled result changed")

    // an empty result register never blocks the input side
    `DSTS_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall, "input stalled with empty output")

    // input only backs up behind a stalled result
    `DSTS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

    // an accepted request has a result waiting after the input and result registers
    `DSTS_ASSERT_NEXT(a_fill, in_valid && !in_stall, ##1 out_valid, "no result after accepted request")

endmodule

bind dual_stepper_turn_sequencer dsts_checker u_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dsts_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1950;

    // half-step coil nibbles, entry 0 in the low nibble
    localparam logic [31:0] LEFT_SEQ  = 32'h8913264C;
    localparam logic [31:0] RIGHT_SEQ = 32'h4623198C;

    typedef struct packed {
        logic [7:0] coil;
        logic       done;
    } coil_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                tick_valid = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [7:0]          coil_pattern;
    logic                turn_done;

    // predictor copy of the registers, index 0 left, 1 right
    logic [PERIOD_W-1:0] cfg_period [2];
    logic [TARGET_W-1:0] cfg_target [2];
    logic [DIR_W-1:0]    cfg_dir [2];
    logic [7:0]          tick_phase [2];
    logic [TARGET_W-1:0] steps_taken [2];
    logic [IDX_W-1:0]    phase_idx [2];

    logic                tick_queue [$];
    coil_result_t        pending_results [$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int                  send_gap = 0;
    int                  stall_left = 0;
    bit                  burst_mode = 1'b0;

    dual_stepper_turn_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick_valid   (tick_valid),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coil_pattern (coil_pattern),
        .turn_done    (turn_done)
    );

    always #10 clk = ~clk;

    function automatic int pick_delay();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 15);
        if (r == 0)
            return $urandom_range(10, 30);
        else if (r < 6)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // one tick request through both wheels, returns the coil byte and done flag
    function automatic coil_result_t advance_turn(input logic tick);
        coil_result_t r;
        int           span;
        r.done = 1'b0;
        if (tick)
        begin
            for (int w = 0; w < 2; w++)
            begin
                span = (cfg_period[w] == 0) ? 256 : int'(cfg_period[w]);
                if (int'(tick_phase[w]) + 1 >= span)
                begin
                    tick_phase[w] = '0;
                    if (steps_taken[w] < cfg_target[w])
                    begin
                        steps_taken[w] = steps_taken[w] + 1'b1;
                        if (cfg_dir[w] == DIR_FWD)
                            phase_idx[w] = phase_idx[w] + 1'b1;
                        else if (cfg_dir[w] == DIR_REV)
                            phase_idx[w] = phase_idx[w] - 1'b1;
                    end
                end
                else
                    tick_phase[w] = tick_phase[w] + 1'b1;
            end
            r.done = (steps_taken[0] >= cfg_target[0]) && (steps_taken[1] >= cfg_target[1]);
        end
        r.coil = '0;
        if (cfg_dir[0] == DIR_FWD || cfg_dir[0] == DIR_REV)
            r.coil[3:0] = LEFT_SEQ[{phase_idx[0], 2'b00} +: 4];
        if (cfg_dir[1] == DIR_FWD || cfg_dir[1] == DIR_REV)
            r.coil[7:4] = RIGHT_SEQ[{phase_idx[1], 2'b00} +: 4];
        if (r.done)
        begin
            tick_phase[0]  = '0;
            tick_phase[1]  = '0;
            steps_taken[0] = '0;
            steps_taken[1] = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // tick request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(advance_turn(tick_valid));
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    in_valid   <= 1'b1;
                    tick_valid <= tick_queue.pop_front();
                    send_gap   <= pick_delay();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        coil_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", coil_pattern, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (coil_pattern !== want.coil)
                        report_mismatch("coil_pattern", coil_pattern, want.coil);
                    if (turn_done !== want.done)
                        report_mismatch("turn_done", turn_done, want.done);
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (!burst_mode && $urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_delay();
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(r));
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_LEFT_PERIOD:  cfg_period[0] = v[PERIOD_W-1:0];
            REG_LEFT_TARGET:  cfg_target[0] = v[TARGET_W-1:0];
            REG_LEFT_DIR:     cfg_dir[0]    = v[DIR_W-1:0];
            REG_RIGHT_PERIOD: cfg_period[1] = v[PERIOD_W-1:0];
            REG_RIGHT_TARGET: cfg_target[1] = v[TARGET_W-1:0];
            REG_RIGHT_DIR:    cfg_dir[1]    = v[DIR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int lp, input int lt, input int ld,
                             input int rp, input int rt, input int rd);
        write_reg(REG_LEFT_PERIOD, lp);
        write_reg(REG_LEFT_TARGET, lt);
        write_reg(REG_LEFT_DIR, ld);
        write_reg(REG_RIGHT_PERIOD, rp);
        write_reg(REG_RIGHT_TARGET, rt);
        write_reg(REG_RIGHT_DIR, rd);
    endtask

    // hold off until every queued request is sent and answered
    task automatic wait_idle();
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_ticks(input int count);
        repeat (count) tick_queue.push_back($urandom_range(0, 6) != 0);
    endtask

    function automatic int rand_period();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        else if (r == 1)
            return 255;
        else if (r == 2)
            return $urandom_range(0, 255);
        return $urandom_range(1, 4);
    endfunction

    function automatic int rand_target();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 0;
        else if (r == 3)
            return 1023;
        else if (r < 6)
            return $urandom_range(0, 1023);
        return $urandom_range(1, 12);
    endfunction

    initial
    begin
        int items_sent;
        int n;
        cfg_period[0]  = RST_PERIOD;
        cfg_period[1]  = RST_PERIOD;
        cfg_target[0]  = RST_TARGET;
        cfg_target[1]  = RST_TARGET;
        cfg_dir[0]     = RST_LEFT_DIR;
        cfg_dir[1]     = RST_RIGHT_DIR;
        tick_phase[0]  = '0;
        tick_phase[1]  = '0;
        steps_taken[0] = '0;
        steps_taken[1] = '0;
        phase_idx[0]   = RST_PHASE_IDX;
        phase_idx[1]   = RST_PHASE_IDX;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset, idle request included
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        wait_idle();

        // both targets zero: done on every tick
        configure(1, 0, DIR_FWD, 1, 0, DIR_REV);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        wait_idle();

        // longest periods, largest targets, both wheels off (code 3 and 0)
        configure(255, 1023, 3, 0, 1023, DIR_OFF);
        repeat (5) tick_queue.push_back(1'b1);
        wait_idle();

        // period dropped below the running phase, then a short turn to done
        configure(2, 2, DIR_REV, 3, 3, DIR_FWD);
        repeat (8) tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        wait_idle();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            configure(rand_period(), rand_target(), $urandom_range(0, 3),
                      rand_period(), rand_target(), $urandom_range(0, 3));
            burst_mode = ($urandom_range(0, 3) == 0);
            n = $urandom_range(30, 120);
            queue_ticks(n);
            items_sent += n;
            wait_idle();
            burst_mode = 1'b0;
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
